>>> hw/rtl/kicker_charge_command_limiter_assert.svh
// Assertion macros for the kicker charge command limiter.
// Each use names the label, the clock, the reset, the trigger, the check and a message.
`ifndef KICKER_CHARGE_COMMAND_LIMITER_ASSERT_SVH
`define KICKER_CHARGE_COMMAND_LIMITER_ASSERT_SVH

// Same-cycle implication
`define KCCL_ASSERT_NOW(label, clk_i, rst_i, trig, chk, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (trig) |-> (chk)) \
    else $error(msg);

// Next-cycle implication
`define KCCL_ASSERT_NEXT(label, clk_i, rst_i, trig, chk, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (trig) |=> (chk)) \
    else $error(msg);

`endif

>>> hw/rtl/kccl_pkg.sv
`default_nettype none

package kccl_pkg;

  // Field widths
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned EstW     = 7;
  localparam int unsigned RampW    = 8;
  localparam int unsigned IdW      = 11;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  // Register reset values
  localparam logic [ElapsedW-1:0] KickCooldownRst   = 10'd500;
  localparam logic [ElapsedW-1:0] ChargeCooldownRst = 10'd100;
  localparam logic [RampW-1:0]    RampPeriodRst     = 8'd50;

  // Estimate and counter limits
  localparam logic [ElapsedW-1:0] ElapsedMax  = '1;
  localparam logic [EstW-1:0]     FullPercent = 7'd100;
  localparam logic [EstW-1:0]     RampCeiling = 7'd99;
  localparam logic [ByteW-1:0]    ByteAll     = 8'hFF;

  typedef enum logic [2:0] {
    REQ_TICK         = 3'd0,
    REQ_KICK         = 3'd1,
    REQ_RESET_DIRECT = 3'd2,
    REQ_CHARGE       = 3'd3,
    REQ_FEEDBACK     = 3'd4
  } req_type_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KICK_COOLDOWN   = 3'd0,
    CFG_CHARGE_COOLDOWN = 3'd1,
    CFG_RAMP_PERIOD     = 3'd2,
    CFG_STRAIGHT_ID     = 3'd3,
    CFG_CHIP_ID         = 3'd4,
    CFG_CHARGE_ID       = 3'd5,
    CFG_DISCHARGE_ID    = 3'd6
  } cfg_index_t;

endpackage

`default_nettype wire

>>> hw/rtl/kicker_charge_command_limiter.sv
`default_nettype none

// Kicker charge command limiter. Each input beat carries one event (s_tuser = req_type):
// a millisecond tick, a kick, a direct reset, a charge/discharge command or charge
// feedback. Every beat yields exactly one output beat; m_tuser flags whether a bus
// frame goes out, and m_tdata always carries the current charge estimate. Kicks and
// charge commands inside their cooldown are dropped (frame flag low, no state change).
// Throughput is one beat per cycle while the sink is ready; a beat passes an input register
// and then a result register, where its result is held until the sink is ready to take it.
// The only limit on rate is back-pressure on the result register. Configuration writes
// take effect on the next cycle and must be made while no beat is in flight.

`include "kicker_charge_command_limiter_assert.svh"

module kicker_charge_command_limiter
  import kccl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration write port
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  // input stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // kick_kind, kick_power, direct_request, charge_request, done_report, mode_report
  input  wire logic [InDataW-1:0]  s_tdata,
  // req_type
  input  wire logic [2:0]          s_tuser,
  // output stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // frame_id, frame_byte0, frame_byte1, frame_byte7, charge_estimate, zero pad
  output logic [OutDataW-1:0]      m_tdata,
  // frame_valid
  output logic [0:0]               m_tuser
);

  // configuration registers
  logic [ElapsedW-1:0] kick_cooldown_ms;
  logic [ElapsedW-1:0] charge_cooldown_ms;
  logic [RampW-1:0]    ramp_period;
  logic [IdW-1:0]      straight_kick_id;
  logic [IdW-1:0]      chip_kick_id;
  logic [IdW-1:0]      charge_start_id;
  logic [IdW-1:0]      discharge_start_id;

  // block state
  logic [ElapsedW-1:0] kick_elapsed,   kick_elapsed_next;
  logic [ElapsedW-1:0] charge_elapsed, charge_elapsed_next;
  logic [EstW-1:0]     cap_estimate,   cap_estimate_next;
  logic [RampW-1:0]    ramp_count,     ramp_count_next;

  // input register
  logic                in_valid;
  req_type_t           in_req;
  logic [ByteW-1:0]    in_kind, in_power, in_direct, in_chreq, in_done, in_mode;

  // result register
  logic                res_valid, res_valid_next;
  logic [IdW-1:0]      res_id,    res_id_next;
  logic [ByteW-1:0]    res_b0,    res_b0_next;
  logic [ByteW-1:0]    res_b1,    res_b1_next;
  logic [ByteW-1:0]    res_b7,    res_b7_next;
  logic [EstW-1:0]     res_est;

  logic advance;
  logic [RampW-1:0] ramp_inc;
  logic [IdW-1:0]   kind_id;

  // pipeline handshake: the input stage moves on whenever the result register frees up
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kick_cooldown_ms   <= KickCooldownRst;
      charge_cooldown_ms <= ChargeCooldownRst;
      ramp_period        <= RampPeriodRst;
      straight_kick_id   <= '0;
      chip_kick_id       <= '0;
      charge_start_id    <= '0;
      discharge_start_id <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_KICK_COOLDOWN:   kick_cooldown_ms   <= cfg_data[ElapsedW-1:0];
        CFG_CHARGE_COOLDOWN: charge_cooldown_ms <= cfg_data[ElapsedW-1:0];
        CFG_RAMP_PERIOD:     ramp_period        <= cfg_data[RampW-1:0];
        CFG_STRAIGHT_ID:     straight_kick_id   <= cfg_data[IdW-1:0];
        CFG_CHIP_ID:         chip_kick_id       <= cfg_data[IdW-1:0];
        CFG_CHARGE_ID:       charge_start_id    <= cfg_data[IdW-1:0];
        CFG_DISCHARGE_ID:    discharge_start_id <= cfg_data[IdW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req    <= req_type_t'(s_tuser);
      in_kind   <= s_tdata[7:0];
      in_power  <= s_tdata[15:8];
      in_direct <= s_tdata[23:16];
      in_chreq  <= s_tdata[31:24];
      in_done   <= s_tdata[39:32];
      in_mode   <= s_tdata[47:40];
    end
  end

  assign kind_id  = (in_kind == '0) ? straight_kick_id : chip_kick_id;
  assign ramp_inc = ramp_count + 1'b1;

  // event decode: state update and frame contents
  always_comb begin
    kick_elapsed_next   = kick_elapsed;
    charge_elapsed_next = charge_elapsed;
    cap_estimate_next   = cap_estimate;
    ramp_count_next     = ramp_count;
    res_valid_next      = 1'b0;
    res_id_next         = '0;
    res_b0_next         = '0;
    res_b1_next         = '0;
    res_b7_next         = '0;
    case (in_req)
      REQ_TICK: begin
        if (kick_elapsed != ElapsedMax) kick_elapsed_next = kick_elapsed + 1'b1;
        if (charge_elapsed != ElapsedMax) charge_elapsed_next = charge_elapsed + 1'b1;
      end
      REQ_KICK: begin
        if (kick_elapsed >= kick_cooldown_ms) begin
          res_valid_next    = 1'b1;
          res_id_next       = kind_id;
          res_b0_next       = in_power;
          res_b1_next       = (in_direct == 8'd1) ? ByteAll : '0;
          kick_elapsed_next = '0;
          // saturating subtract of the kick power
          if (in_power > {1'b0, cap_estimate}) cap_estimate_next = '0;
          else cap_estimate_next = cap_estimate - in_power[EstW-1:0];
        end
      end
      REQ_RESET_DIRECT: begin
        res_valid_next = 1'b1;
        res_id_next    = kind_id;
        res_b7_next    = ByteAll;
      end
      REQ_CHARGE: begin
        if (charge_elapsed >= charge_cooldown_ms) begin
          res_valid_next      = 1'b1;
          charge_elapsed_next = '0;
          if (in_chreq == '0) begin
            res_id_next = charge_start_id;
          end else begin
            res_id_next       = discharge_start_id;
            cap_estimate_next = '0;
          end
        end
      end
      REQ_FEEDBACK: begin
        if (in_done == ByteAll) begin
          cap_estimate_next = FullPercent;
        end else if (in_mode == ByteAll && cap_estimate < RampCeiling) begin
          // slow ramp: one percent per ramp_period charging reports
          if (ramp_inc >= ramp_period) begin
            ramp_count_next   = '0;
            cap_estimate_next = cap_estimate + 1'b1;
          end else begin
            ramp_count_next = ramp_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kick_elapsed   <= '0;
      charge_elapsed <= '0;
      cap_estimate   <= '0;
      ramp_count     <= '0;
    end else if (advance) begin
      kick_elapsed   <= kick_elapsed_next;
      charge_elapsed <= charge_elapsed_next;
      cap_estimate   <= cap_estimate_next;
      ramp_count     <= ramp_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_valid <= res_valid_next;
      res_id    <= res_id_next;
      res_b0    <= res_b0_next;
      res_b1    <= res_b1_next;
      res_b7    <= res_b7_next;
      res_est   <= cap_estimate_next;
    end
  end

  assign m_tuser = res_valid;
  assign m_tdata = {6'd0, res_est, res_b7, res_b1, res_b0, res_id};

  // checks
  `KCCL_ASSERT_NOW(a_est_range, clk, rst, 1'b1, cap_estimate <= FullPercent,
    "charge estimate above full")
  `KCCL_ASSERT_NOW(a_no_frame_zero, clk, rst, m_tvalid && !m_tuser[0],
    m_tdata[34:0] == '0, "dropped beat carries frame bytes")
  `KCCL_ASSERT_NEXT(a_kick_restart, clk, rst, advance && in_req == REQ_KICK && res_valid_next,
    kick_elapsed == '0, "sent kick did not restart cooldown")
  `KCCL_ASSERT_NOW(a_stall_cause, clk, rst, !s_tready, in_valid && m_tvalid && !m_tready,
    "input stalled without output back-pressure")

endmodule

`default_nettype wire
